FILE: sv/uqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uqs_pkg
// Shared types, codes and helpers of the URI query splitter.
// ----------------------------------------------------------------------------
package uqs_pkg;

  localparam int unsigned MAX_PARAMS_DEF = 255;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_EQUALS   = 8'h3D;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_PERCENT  = 8'h25;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PART_RES = 2'd0,
    PART_KEY = 2'd1,
    PART_VAL = 2'd2
  } part_t;

  typedef enum logic [1:0] {
    ERR_BAD_HEX   = 2'd0,
    ERR_NO_EQUALS = 2'd1,
    ERR_TRUNCATED = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    PH_RES  = 2'd0,
    PH_KEY  = 2'd1,
    PH_VAL  = 2'd2,
    PH_DROP = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    part_t      part;
    logic [7:0] param_index;
    err_t       error_code;
    logic       last;
  } res_t;

  // results of one decoded byte, packed into the low slots
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  // bit 4 set when the byte is a hex digit, low nibble its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: sv/uqs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uqs_if
// Valid/ready channels for raw URI bytes and for tagged results.
// ----------------------------------------------------------------------------
interface uqs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_uri;

  modport source (output valid, output char_in, output end_of_uri, input ready);
  modport sink (input valid, input char_in, input end_of_uri, output ready);
endinterface

interface uqs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [1:0] part;
  logic [7:0] param_index;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output kind, output data_byte, output part,
                  output param_index, output error_code, output last, input ready);
  modport sink (input valid, input kind, input data_byte, input part,
                input param_index, input error_code, input last, output ready);
endinterface

FILE: sv/uri_query_splitter_percent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_query_splitter_percent_decoder
// Splits a URI byte stream into resource, key and value parts, with percent
// decoding of keys and values.
// ----------------------------------------------------------------------------
// in_ch takes one raw URI byte per transfer, end_of_uri set on the final byte.
// out_ch delivers tagged results: data bytes, part-end markers carrying the
// parameter index (saturating at MAX_PARAMS), and error results that end the
// URI early. The final result of every URI carries last.
// Each byte gives zero, one or two results; two only on the final byte.
// Each byte passes the input register and then the result queue on its way to
// out_ch. Throughput: one byte per cycle while the queue has room; the input
// register feeds a one-pass decoder that writes a four-entry result queue, and
// the decoder advances while the queue holds at most two results.
// When out_ch stalls, the queue fills and in_ch.ready drops; nothing is lost.
// A synchronous active-low reset empties the queue and returns the parser to
// the resource part with the parameter index at zero.
// ----------------------------------------------------------------------------
module uri_query_splitter_percent_decoder #(
  parameter int unsigned MAX_PARAMS = uqs_pkg::MAX_PARAMS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  uqs_in_if.sink   in_ch,
  uqs_out_if.source out_ch
);

  logic           s_valid_r, s_valid_nxt;
  logic [7:0]     s_char_r;
  logic           s_eou_r;
  logic           room, dec_fire, in_fire;
  uqs_pkg::push_t push;
  uqs_pkg::res_t  head;

  assign dec_fire    = s_valid_r && room;
  assign in_ch.ready = !s_valid_r || room;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_fire) begin
      s_valid_nxt = 1'b1;
    end else if (dec_fire) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_char_r <= in_ch.char_in;
      s_eou_r  <= in_ch.end_of_uri;
    end
  end

  uqs_decode #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (dec_fire),
    .char_in    (s_char_r),
    .end_of_uri (s_eou_r),
    .push       (push)
  );

  uqs_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (head)
  );

  assign out_ch.kind        = head.kind;
  assign out_ch.data_byte   = head.data_byte;
  assign out_ch.part        = head.part;
  assign out_ch.param_index = head.param_index;
  assign out_ch.error_code  = head.error_code;
  assign out_ch.last        = head.last;

endmodule

FILE: sv/uqs_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uqs_decode
// Parser state and single-pass decode of one byte into up to two results.
// ----------------------------------------------------------------------------
module uqs_decode #(
  parameter int unsigned MAX_PARAMS = uqs_pkg::MAX_PARAMS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    char_in,
  input  logic          end_of_uri,
  output uqs_pkg::push_t push
);

  localparam int unsigned ParamW = $clog2(MAX_PARAMS + 1);

  uqs_pkg::phase_t   phase_r, phase_nxt;
  uqs_pkg::esc_t     esc_r, esc_nxt;
  logic [3:0]        hi_r, hi_nxt;
  logic [ParamW-1:0] cur_r, cur_nxt;

  uqs_pkg::res_t     first, fin_res;
  logic              first_v, fin_v, failed;
  logic [4:0]        hx;
  logic [7:0]        ender;
  uqs_pkg::part_t    part;
  logic [ParamW+7:0] idx_now, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uqs_pkg::PH_RES;
      esc_r   <= uqs_pkg::ESC_IDLE;
      hi_r    <= 4'd0;
      cur_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      hi_r    <= hi_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    hi_nxt    = hi_r;
    cur_nxt   = cur_r;
    first     = '0;
    fin_res   = '0;
    first_v   = 1'b0;
    fin_v     = 1'b0;
    failed    = 1'b0;
    hx        = uqs_pkg::hex_digit(char_in);
    ender     = (phase_r == uqs_pkg::PH_KEY) ? uqs_pkg::CH_EQUALS : uqs_pkg::CH_AMP;
    part      = (phase_r == uqs_pkg::PH_KEY) ? uqs_pkg::PART_KEY : uqs_pkg::PART_VAL;
    idx_now   = {8'd0, cur_r};
    idx_nxt   = '0;

    first.param_index = idx_now[7:0];

    case (phase_r)
      uqs_pkg::PH_DROP: begin
        // error already reported, wait for the final byte
      end
      uqs_pkg::PH_RES: begin
        first_v   = 1'b1;
        first.part = uqs_pkg::PART_RES;
        if (char_in == uqs_pkg::CH_QUESTION) begin
          first.kind = uqs_pkg::KIND_END;
          phase_nxt  = uqs_pkg::PH_KEY;
        end else begin
          first.kind      = uqs_pkg::KIND_DATA;
          first.data_byte = char_in;
        end
      end
      default: begin
        first.part = part;
        if (esc_r != uqs_pkg::ESC_IDLE) begin
          if (!hx[4]) begin
            first_v          = 1'b1;
            first.kind       = uqs_pkg::KIND_ERROR;
            first.error_code = (char_in == ender) ? uqs_pkg::ERR_TRUNCATED
                                                  : uqs_pkg::ERR_BAD_HEX;
            first.last       = 1'b1;
            failed           = 1'b1;
          end else if (esc_r == uqs_pkg::ESC_HIGH) begin
            hi_nxt  = hx[3:0];
            esc_nxt = uqs_pkg::ESC_LOW;
          end else begin
            first_v         = 1'b1;
            first.kind      = uqs_pkg::KIND_DATA;
            first.data_byte = {hi_r, hx[3:0]};
            esc_nxt         = uqs_pkg::ESC_IDLE;
          end
        end else if (char_in == uqs_pkg::CH_PERCENT) begin
          esc_nxt = uqs_pkg::ESC_HIGH;
        end else if (phase_r == uqs_pkg::PH_KEY && char_in == uqs_pkg::CH_AMP) begin
          first_v          = 1'b1;
          first.kind       = uqs_pkg::KIND_ERROR;
          first.error_code = uqs_pkg::ERR_NO_EQUALS;
          first.last       = 1'b1;
          failed           = 1'b1;
        end else if (char_in == ender) begin
          first_v    = 1'b1;
          first.kind = uqs_pkg::KIND_END;
          if (phase_r == uqs_pkg::PH_KEY) begin
            phase_nxt = uqs_pkg::PH_VAL;
          end else begin
            if (cur_r < ParamW'(MAX_PARAMS)) begin
              cur_nxt = cur_r + 1'b1;
            end
            phase_nxt = uqs_pkg::PH_KEY;
          end
        end else begin
          first_v         = 1'b1;
          first.kind      = uqs_pkg::KIND_DATA;
          first.data_byte = char_in;
        end
      end
    endcase

    idx_nxt             = {8'd0, cur_nxt};
    fin_res.param_index = idx_nxt[7:0];
    fin_res.last        = 1'b1;

    if (phase_r == uqs_pkg::PH_DROP) begin
      if (end_of_uri) begin
        phase_nxt = uqs_pkg::PH_RES;
        esc_nxt   = uqs_pkg::ESC_IDLE;
        hi_nxt    = 4'd0;
        cur_nxt   = '0;
      end
    end else if (failed) begin
      if (end_of_uri) begin
        phase_nxt = uqs_pkg::PH_RES;
        esc_nxt   = uqs_pkg::ESC_IDLE;
        hi_nxt    = 4'd0;
        cur_nxt   = '0;
      end else begin
        phase_nxt = uqs_pkg::PH_DROP;
      end
    end else if (end_of_uri) begin
      fin_v = 1'b1;
      case (phase_nxt)
        uqs_pkg::PH_RES: begin
          fin_res.kind = uqs_pkg::KIND_END;
          fin_res.part = uqs_pkg::PART_RES;
        end
        uqs_pkg::PH_KEY: begin
          fin_res.kind       = uqs_pkg::KIND_ERROR;
          fin_res.part       = uqs_pkg::PART_KEY;
          fin_res.error_code = uqs_pkg::ERR_NO_EQUALS;
        end
        default: begin
          fin_res.part = uqs_pkg::PART_VAL;
          if (esc_nxt != uqs_pkg::ESC_IDLE) begin
            fin_res.kind       = uqs_pkg::KIND_ERROR;
            fin_res.error_code = uqs_pkg::ERR_TRUNCATED;
          end else begin
            fin_res.kind = uqs_pkg::KIND_END;
          end
        end
      endcase
      phase_nxt = uqs_pkg::PH_RES;
      esc_nxt   = uqs_pkg::ESC_IDLE;
      hi_nxt    = 4'd0;
      cur_nxt   = '0;
    end

    push = '0;
    if (fire) begin
      push.cnt  = 2'(first_v) + 2'(fin_v);
      push.res0 = first_v ? first : fin_res;
      push.res1 = fin_res;
    end
  end

endmodule

FILE: sv/uqs_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uqs_out_queue
// Small result queue that takes up to two results per cycle, drains one.
// ----------------------------------------------------------------------------
module uqs_out_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  uqs_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output uqs_pkg::res_t  out_res
);

  localparam int unsigned AddrW = $clog2(uqs_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(uqs_pkg::QUEUE_DEPTH + 1);

  uqs_pkg::res_t    mem_r [uqs_pkg::QUEUE_DEPTH];
  logic [AddrW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             pop;

  assign pop       = (cnt_r != '0) && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[head_r];
  assign room      = (cnt_r <= CntW'(uqs_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    head_nxt = head_r + AddrW'(pop);
    tail_nxt = tail_r + AddrW'(push.cnt);
    cnt_nxt  = cnt_r + CntW'(push.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[tail_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[tail_r + AddrW'(1)] <= push.res1;
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the URI query splitter. Sends whole URIs byte by byte: a short
// directed set of corner cases, then mostly well-formed random URIs with some
// corrupted ones and one that runs the parameter index into saturation. A
// scoreboard tracks the parser state, predicts the tagged results of every
// accepted byte and checks them in order against the output channel.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_P       = uqs_pkg::MAX_PARAMS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEM_COUNT  = 1050;

  class split_tracker;
    uqs_pkg::res_t   parts_due[$];
    uqs_pkg::phase_t phase;
    uqs_pkg::esc_t   esc;
    logic [3:0]      hi_nib;
    int unsigned     param_cnt;
    int unsigned     max_params;
    int              errors;

    function new(int unsigned mp);
      max_params = mp;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      phase     = uqs_pkg::PH_RES;
      esc       = uqs_pkg::ESC_IDLE;
      hi_nib    = 4'd0;
      param_cnt = 0;
    endfunction

    function void push(uqs_pkg::kind_t k, logic [7:0] b, uqs_pkg::part_t p,
                       uqs_pkg::err_t e, logic l);
      uqs_pkg::res_t r;
      r.kind        = k;
      r.data_byte   = b;
      r.part        = p;
      r.param_index = param_cnt[7:0];
      r.error_code  = e;
      r.last        = l;
      parts_due.push_back(r);
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
      return -1;
    endfunction

    // returns 1 when the byte is dropped without effect on the output
    function bit parse_byte(logic [7:0] c, logic fin);
      uqs_pkg::part_t pt;
      logic [7:0]     ender;
      int             h;
      bit             failed;
      failed = 1'b0;
      if (phase == uqs_pkg::PH_DROP) begin
        if (fin) restart();
        return 1'b1;
      end
      if (phase == uqs_pkg::PH_RES) begin
        if (c == uqs_pkg::CH_QUESTION) begin
          push(uqs_pkg::KIND_END, 8'h00, uqs_pkg::PART_RES, uqs_pkg::ERR_BAD_HEX, 1'b0);
          phase = uqs_pkg::PH_KEY;
        end else begin
          push(uqs_pkg::KIND_DATA, c, uqs_pkg::PART_RES, uqs_pkg::ERR_BAD_HEX, 1'b0);
        end
      end else begin
        pt    = (phase == uqs_pkg::PH_KEY) ? uqs_pkg::PART_KEY : uqs_pkg::PART_VAL;
        ender = (phase == uqs_pkg::PH_KEY) ? uqs_pkg::CH_EQUALS : uqs_pkg::CH_AMP;
        if (esc != uqs_pkg::ESC_IDLE) begin
          h = nibble_of(c);
          if (h < 0) begin
            push(uqs_pkg::KIND_ERROR, 8'h00, pt,
                 (c == ender) ? uqs_pkg::ERR_TRUNCATED : uqs_pkg::ERR_BAD_HEX, 1'b1);
            failed = 1'b1;
          end else if (esc == uqs_pkg::ESC_HIGH) begin
            hi_nib = h[3:0];
            esc    = uqs_pkg::ESC_LOW;
          end else begin
            push(uqs_pkg::KIND_DATA, {hi_nib, h[3:0]}, pt, uqs_pkg::ERR_BAD_HEX, 1'b0);
            esc = uqs_pkg::ESC_IDLE;
          end
        end else if (c == uqs_pkg::CH_PERCENT) begin
          esc = uqs_pkg::ESC_HIGH;
        end else if (phase == uqs_pkg::PH_KEY && c == uqs_pkg::CH_AMP) begin
          push(uqs_pkg::KIND_ERROR, 8'h00, pt, uqs_pkg::ERR_NO_EQUALS, 1'b1);
          failed = 1'b1;
        end else if (c == ender) begin
          push(uqs_pkg::KIND_END, 8'h00, pt, uqs_pkg::ERR_BAD_HEX, 1'b0);
          if (phase == uqs_pkg::PH_KEY) begin
            phase = uqs_pkg::PH_VAL;
          end else begin
            if (param_cnt < max_params) param_cnt++;
            phase = uqs_pkg::PH_KEY;
          end
        end else begin
          push(uqs_pkg::KIND_DATA, c, pt, uqs_pkg::ERR_BAD_HEX, 1'b0);
        end
      end
      if (failed) begin
        if (fin) restart();
        else phase = uqs_pkg::PH_DROP;
        return 1'b0;
      end
      if (fin) begin
        if (phase == uqs_pkg::PH_RES)
          push(uqs_pkg::KIND_END, 8'h00, uqs_pkg::PART_RES, uqs_pkg::ERR_BAD_HEX, 1'b1);
        else if (phase == uqs_pkg::PH_KEY)
          push(uqs_pkg::KIND_ERROR, 8'h00, uqs_pkg::PART_KEY, uqs_pkg::ERR_NO_EQUALS, 1'b1);
        else if (esc != uqs_pkg::ESC_IDLE)
          push(uqs_pkg::KIND_ERROR, 8'h00, uqs_pkg::PART_VAL, uqs_pkg::ERR_TRUNCATED, 1'b1);
        else
          push(uqs_pkg::KIND_END, 8'h00, uqs_pkg::PART_VAL, uqs_pkg::ERR_BAD_HEX, 1'b1);
        restart();
      end
      return 1'b0;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(uqs_pkg::res_t got);
      uqs_pkg::res_t want;
      if (parts_due.size() == 0) begin
        $error("unexpected result: kind %0d, byte 0x%0h", got.kind, got.data_byte);
        errors++;
        return;
      end
      want = parts_due.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("part", want.part, got.part);
      check_field("param_index", want.param_index, got.param_index);
      check_field("error_code", want.error_code, got.error_code);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  bit           calm;
  int unsigned  cycles;
  int unsigned  sent_items;
  int unsigned  uri_count;
  logic [7:0]   byte_q[$];
  split_tracker tracker;

  uqs_in_if  in_ch();
  uqs_out_if out_ch();

  uri_query_splitter_percent_decoder #(.MAX_PARAMS(MAX_P)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb failed");
    $finish;
  end

  // result side: check every transfer, then pick the next ready
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        tracker.match_result(uqs_pkg::res_t'({out_ch.kind, out_ch.data_byte, out_ch.part,
                                              out_ch.param_index, out_ch.error_code,
                                              out_ch.last}));
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 14);
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic fin);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_in    <= c;
    in_ch.end_of_uri <= fin;
    do @(posedge clk); while (!in_ch.ready);
    void'(tracker.parse_byte(c, fin));
    sent_items++;
  endtask

  task automatic send_uri();
    foreach (byte_q[i]) send_byte(byte_q[i], i == byte_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.parts_due.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] plain_byte(logic [7:0] x0, logic [7:0] x1, logic [7:0] x2);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == x0 || c == x1 || c == x2);
    return c;
  endfunction

  // key or value text, about a third of it escaped
  function automatic void add_text(int unsigned n, logic [7:0] x0, logic [7:0] x1,
                                   logic [7:0] x2);
    repeat (n) begin
      if ($urandom_range(0, 99) < 30) begin
        byte_q.push_back(uqs_pkg::CH_PERCENT);
        byte_q.push_back(hex_char(4'($urandom_range(0, 15))));
        byte_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end else begin
        byte_q.push_back(plain_byte(x0, x1, x2));
      end
    end
  endfunction

  function automatic void build_uri(int unsigned n_par, int unsigned max_len);
    byte_q.delete();
    repeat ($urandom_range(0, 5)) byte_q.push_back(plain_byte(uqs_pkg::CH_QUESTION,
                                                              uqs_pkg::CH_QUESTION,
                                                              uqs_pkg::CH_QUESTION));
    if (n_par > 0) begin
      byte_q.push_back(uqs_pkg::CH_QUESTION);
      for (int p = 0; p < n_par; p++) begin
        if (p > 0) byte_q.push_back(uqs_pkg::CH_AMP);
        add_text($urandom_range(0, max_len), uqs_pkg::CH_PERCENT, uqs_pkg::CH_EQUALS,
                 uqs_pkg::CH_AMP);
        byte_q.push_back(uqs_pkg::CH_EQUALS);
        add_text($urandom_range(0, max_len), uqs_pkg::CH_PERCENT, uqs_pkg::CH_AMP,
                 uqs_pkg::CH_AMP);
      end
      if ($urandom_range(0, 9) == 0) byte_q.push_back(uqs_pkg::CH_AMP);
    end
    if (byte_q.size() == 0) byte_q.push_back(plain_byte(uqs_pkg::CH_QUESTION,
                                                        uqs_pkg::CH_QUESTION,
                                                        uqs_pkg::CH_QUESTION));
  endfunction

  // corrupt a uri: stray delimiters, non-hex digits, cut tail
  function automatic void mangle_uri();
    int unsigned pos;
    repeat ($urandom_range(1, 2)) begin
      pos = $urandom_range(0, byte_q.size() - 1);
      case ($urandom_range(0, 5))
        0: byte_q[pos] = uqs_pkg::CH_PERCENT;
        1: byte_q[pos] = uqs_pkg::CH_EQUALS;
        2: byte_q[pos] = uqs_pkg::CH_AMP;
        3: byte_q[pos] = uqs_pkg::CH_QUESTION;
        4: byte_q[pos] = 8'h67;
        default: byte_q[pos] = 8'($urandom_range(0, 255));
      endcase
    end
    if ($urandom_range(0, 2) == 0 && byte_q.size() > 1) begin
      repeat ($urandom_range(1, byte_q.size() - 1)) void'(byte_q.pop_back());
    end
  endfunction

  initial begin
    tracker          = new(MAX_P);
    calm             = 1'b0;
    sent_items       = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.char_in    <= 8'h00;
    in_ch.end_of_uri <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // raw percent and zero byte in resource, both hex cases, '=' inside a
    // value, empty key, value ending with an escape pending
    byte_q = '{uqs_pkg::CH_PERCENT, 8'h00, uqs_pkg::CH_QUESTION, uqs_pkg::CH_PERCENT,
               "4", "a", uqs_pkg::CH_EQUALS, uqs_pkg::CH_EQUALS, uqs_pkg::CH_PERCENT,
               "F", "0", uqs_pkg::CH_AMP, uqs_pkg::CH_EQUALS, uqs_pkg::CH_PERCENT};
    send_uri();
    // escape cut by '=' in a key
    byte_q = '{uqs_pkg::CH_QUESTION, uqs_pkg::CH_PERCENT, uqs_pkg::CH_EQUALS};
    send_uri();
    // escape cut by '&' in a value
    byte_q = '{uqs_pkg::CH_QUESTION, uqs_pkg::CH_EQUALS, uqs_pkg::CH_PERCENT,
               uqs_pkg::CH_AMP};
    send_uri();
    // non-hex digit, then bytes dropped up to the end
    byte_q = '{uqs_pkg::CH_QUESTION, uqs_pkg::CH_PERCENT, "g", uqs_pkg::CH_QUESTION};
    send_uri();
    // parameter without '='
    byte_q = '{uqs_pkg::CH_QUESTION, uqs_pkg::CH_AMP};
    send_uri();
    // uri ends in a key with an escape pending
    byte_q = '{uqs_pkg::CH_QUESTION, uqs_pkg::CH_PERCENT};
    send_uri();
    // empty query
    byte_q = '{uqs_pkg::CH_QUESTION};
    send_uri();

    wait_drained();

    uri_count = 0;
    while (sent_items < ITEM_COUNT) begin
      calm = (uri_count >= 6 && uri_count < 16);
      if (uri_count == 3) begin
        build_uri(MAX_P + 3, 0);
      end else begin
        build_uri(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4), 4);
        if ($urandom_range(0, 99) < 20) mangle_uri();
      end
      send_uri();
      uri_count++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

FILE: files.f
sv/uqs_pkg.sv
sv/uqs_if.sv
sv/uqs_decode.sv
sv/uqs_out_queue.sv
sv/uri_query_splitter_percent_decoder.sv
dv/tb.sv
